### rtl/nearest_shadow_caster_select_assert.svh
// Assertion macros for the nearest shadow caster select block.
`ifndef NEAREST_SHADOW_CASTER_SELECT_ASSERT_SVH
`define NEAREST_SHADOW_CASTER_SELECT_ASSERT_SVH

`ifndef SYNTHESIS
`define NSCS_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define NSCS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define NSCS_ASSERT_ALWAYS(label, expr)
`define NSCS_ASSERT_NEXT(label, pre, post)
`endif

`endif

### rtl/nscs_pkg.sv
package nscs_pkg;

  localparam int COORD_W    = 20;
  localparam int ABS_W      = COORD_W;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int DIST_W     = 42;
  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int IDX_W      = 8;
  localparam int CNT_SAT    = SLOT_COUNT + 1;
  localparam int CNT_W      = $clog2(CNT_SAT + 1);
  localparam int AXES       = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] light_x;
    logic signed [COORD_W-1:0] light_y;
    logic signed [COORD_W-1:0] light_z;
    logic                      casts_shadow;
    logic                      last_light;
  } light_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_number;
    logic              slot_valid;
    logic [IDX_W-1:0]  chosen_light;
    logic [DIST_W-1:0] distance_squared;
    logic              casters_dropped;
    logic              last_slot;
  } slot_t;

  typedef struct packed {
    logic                       casts;
    logic                       last;
    logic [IDX_W-1:0]           idx;
    logic [AXES-1:0][SQ_W-1:0]  sq;
  } stage_t;

endpackage

### rtl/nscs_dist.sv
module nscs_dist (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   advance,
  input  logic                                   valid,
  input  nscs_pkg::light_t                       light,
  input  logic [nscs_pkg::IDX_W-1:0]             idx,
  input  logic signed [nscs_pkg::COORD_W-1:0]    camera_x,
  input  logic signed [nscs_pkg::COORD_W-1:0]    camera_y,
  input  logic signed [nscs_pkg::COORD_W-1:0]    camera_z,
  output logic                                   stage_valid,
  output nscs_pkg::stage_t                       stage
);

  logic signed [nscs_pkg::COORD_W-1:0] pos [nscs_pkg::AXES];
  logic signed [nscs_pkg::COORD_W-1:0] cam [nscs_pkg::AXES];
  logic        [nscs_pkg::COORD_W:0]   diff [nscs_pkg::AXES];
  logic        [nscs_pkg::ABS_W-1:0]   mag [nscs_pkg::AXES];
  logic [nscs_pkg::AXES-1:0][nscs_pkg::SQ_W-1:0] sq;

  assign pos[0] = light.light_x;
  assign pos[1] = light.light_y;
  assign pos[2] = light.light_z;
  assign cam[0] = camera_x;
  assign cam[1] = camera_y;
  assign cam[2] = camera_z;

  always_comb begin
    for (int a = 0; a < nscs_pkg::AXES; a++) begin
      diff[a] = {pos[a][nscs_pkg::COORD_W-1], pos[a]} - {cam[a][nscs_pkg::COORD_W-1], cam[a]};
      if (diff[a][nscs_pkg::COORD_W]) begin
        mag[a] = nscs_pkg::ABS_W'(~diff[a] + 1'b1);
      end else begin
        mag[a] = nscs_pkg::ABS_W'(diff[a]);
      end
      sq[a] = nscs_pkg::SQ_W'(mag[a]) * nscs_pkg::SQ_W'(mag[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage.casts <= light.casts_shadow;
      stage.last  <= light.last_light;
      stage.idx   <= idx;
      stage.sq    <= sq;
    end
  end

endmodule

### rtl/nscs_insert.sv
module nscs_insert (
  input  logic [nscs_pkg::DIST_W-1:0] best_dist [nscs_pkg::SLOT_COUNT],
  input  logic [nscs_pkg::IDX_W-1:0]  best_idx  [nscs_pkg::SLOT_COUNT],
  input  logic [nscs_pkg::CNT_W-1:0]  count,
  input  logic [nscs_pkg::DIST_W-1:0] cand_dist,
  input  logic [nscs_pkg::IDX_W-1:0]  idx,
  output logic [nscs_pkg::DIST_W-1:0] new_dist  [nscs_pkg::SLOT_COUNT],
  output logic [nscs_pkg::IDX_W-1:0]  new_idx   [nscs_pkg::SLOT_COUNT]
);

  logic [nscs_pkg::SLOT_COUNT-1:0] keep;

  always_comb begin
    for (int k = 0; k < nscs_pkg::SLOT_COUNT; k++) begin
      keep[k] = (nscs_pkg::CNT_W'(k) < count) && (best_dist[k] <= cand_dist);
    end
    if (keep[0]) begin
      new_dist[0] = best_dist[0];
      new_idx[0]  = best_idx[0];
    end else begin
      new_dist[0] = cand_dist;
      new_idx[0]  = idx;
    end
    for (int k = 1; k < nscs_pkg::SLOT_COUNT; k++) begin
      if (keep[k]) begin
        new_dist[k] = best_dist[k];
        new_idx[k]  = best_idx[k];
      end else if (keep[k-1]) begin
        new_dist[k] = cand_dist;
        new_idx[k]  = idx;
      end else begin
        new_dist[k] = best_dist[k-1];
        new_idx[k]  = best_idx[k-1];
      end
    end
  end

endmodule

### rtl/nearest_shadow_caster_select.sv
// Nearest shadow caster select.
// Lights enter on the lights channel (valid/ready), one item per cycle. Each
// light takes its arrival index from a counter. Casters are ranked by squared
// distance to the camera set through the cfg channel (index 0..2 = x, y, z;
// cfg_ready is always high; write only while idle).
// Stage one squares the per-axis differences; stage two sums them and inserts
// into a sorted four-entry buffer, ties keeping the earlier light ahead.
// A light marked last closes the frame: the buffer is copied to an output
// bank and the live buffer and counters clear, so the next frame follows at
// once. The bank sends four slot items on the slots channel, nearest first,
// one per cycle; the first is offered once the last light has passed stage
// two into the bank and can be taken at once; the fourth carries last_slot.
// Throughput: one light per cycle. A further last light waits in stage two
// only while the bank still holds slot items; lights_ready drops then, and a
// stalled slots receiver holds the bank and its current item unchanged.
// Reset (synchronous, rst high) empties the pipeline, the buffer and the
// bank and sets the camera to the origin.
`include "nearest_shadow_caster_select_assert.svh"

module nearest_shadow_caster_select (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              lights_valid,
  output logic                              lights_ready,
  input  nscs_pkg::light_t                  lights,
  output logic                              slots_valid,
  input  logic                              slots_ready,
  output nscs_pkg::slot_t                   slots,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nscs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nscs_pkg::COORD_W-1:0]      cfg_data
);

  logic signed [nscs_pkg::COORD_W-1:0] camera_x;
  logic signed [nscs_pkg::COORD_W-1:0] camera_y;
  logic signed [nscs_pkg::COORD_W-1:0] camera_z;
  logic [nscs_pkg::IDX_W-1:0]          arrival;

  logic                                s1_valid;
  nscs_pkg::stage_t                    stage;

  logic [nscs_pkg::DIST_W-1:0] best_dist [nscs_pkg::SLOT_COUNT];
  logic [nscs_pkg::IDX_W-1:0]  best_idx  [nscs_pkg::SLOT_COUNT];
  logic [nscs_pkg::DIST_W-1:0] ins_dist  [nscs_pkg::SLOT_COUNT];
  logic [nscs_pkg::IDX_W-1:0]  ins_idx   [nscs_pkg::SLOT_COUNT];
  logic [nscs_pkg::CNT_W-1:0]  live_count;
  logic [nscs_pkg::CNT_W-1:0]  count_next;
  logic [nscs_pkg::DIST_W-1:0] light_dist;

  logic [nscs_pkg::DIST_W-1:0] snap_dist [nscs_pkg::SLOT_COUNT];
  logic [nscs_pkg::IDX_W-1:0]  snap_idx  [nscs_pkg::SLOT_COUNT];
  logic [nscs_pkg::CNT_W-1:0]  snap_count;
  logic [nscs_pkg::SLOT_W-1:0] snap_slot;
  logic                        snap_busy;

  logic slot_take;
  logic snap_free;
  logic s1_ok;
  logic s1_fire;
  logic lights_take;
  logic filled_slot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nscs_pkg::CFG_CAMERA_X: camera_x <= cfg_data;
        nscs_pkg::CFG_CAMERA_Y: camera_y <= cfg_data;
        nscs_pkg::CFG_CAMERA_Z: camera_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign slot_take    = slots_valid && slots_ready
                        && (snap_slot == nscs_pkg::SLOT_W'(nscs_pkg::SLOT_COUNT - 1));
  assign snap_free    = !snap_busy || slot_take;
  assign s1_ok        = !(s1_valid && stage.last) || snap_free;
  assign lights_ready = !s1_valid || s1_ok;
  assign s1_fire      = s1_valid && s1_ok;
  assign lights_take  = lights_valid && lights_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival <= '0;
    end else if (lights_take) begin
      arrival <= lights.last_light ? '0 : arrival + 1'b1;
    end
  end

  nscs_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .advance     (lights_ready),
    .valid       (lights_valid),
    .light       (lights),
    .idx         (arrival),
    .camera_x    (camera_x),
    .camera_y    (camera_y),
    .camera_z    (camera_z),
    .stage_valid (s1_valid),
    .stage       (stage)
  );

  assign light_dist = nscs_pkg::DIST_W'(stage.sq[0]) + nscs_pkg::DIST_W'(stage.sq[1])
                      + nscs_pkg::DIST_W'(stage.sq[2]);

  nscs_insert u_insert (
    .best_dist (best_dist),
    .best_idx  (best_idx),
    .count     (live_count),
    .cand_dist (light_dist),
    .idx       (stage.idx),
    .new_dist  (ins_dist),
    .new_idx   (ins_idx)
  );

  always_comb begin
    count_next = live_count;
    if (stage.casts && (live_count != nscs_pkg::CNT_W'(nscs_pkg::CNT_SAT))) begin
      count_next = live_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else if (s1_fire) begin
      live_count <= stage.last ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && stage.casts) begin
      best_dist <= ins_dist;
      best_idx  <= ins_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && stage.last) begin
      snap_count <= count_next;
      if (stage.casts) begin
        snap_dist <= ins_dist;
        snap_idx  <= ins_idx;
      end else begin
        snap_dist <= best_dist;
        snap_idx  <= best_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_busy <= 1'b0;
      snap_slot <= '0;
    end else if (s1_fire && stage.last) begin
      snap_busy <= 1'b1;
      snap_slot <= '0;
    end else if (slots_valid && slots_ready) begin
      snap_slot <= snap_slot + 1'b1;
      if (slot_take) begin
        snap_busy <= 1'b0;
      end
    end
  end

  assign filled_slot = nscs_pkg::CNT_W'(snap_slot) < snap_count;
  assign slots_valid = snap_busy;

  always_comb begin
    slots.slot_number      = snap_slot;
    slots.slot_valid       = filled_slot;
    slots.chosen_light     = filled_slot ? snap_idx[snap_slot] : '0;
    slots.distance_squared = filled_slot ? snap_dist[snap_slot] : '0;
    slots.casters_dropped  = snap_count > nscs_pkg::CNT_W'(nscs_pkg::SLOT_COUNT);
    slots.last_slot        = snap_slot == nscs_pkg::SLOT_W'(nscs_pkg::SLOT_COUNT - 1);
  end

  `NSCS_ASSERT_ALWAYS(a_stall_cause, !lights_ready |-> (s1_valid && stage.last && snap_busy))
  `NSCS_ASSERT_ALWAYS(a_empty_zero, (slots_valid && !slots.slot_valid) |-> (slots.chosen_light == '0 && slots.distance_squared == '0))
  `NSCS_ASSERT_ALWAYS(a_sorted_01, (live_count >= nscs_pkg::CNT_W'(2)) |-> (best_dist[0] <= best_dist[1]))
  `NSCS_ASSERT_NEXT(a_bank_done, (slot_take && !(s1_valid && stage.last)), !slots_valid)

endmodule

### tb/sv/shadow_slot_checker.sv
module shadow_slot_checker
  import nscs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  lights_valid,
  input  logic                  lights_ready,
  input  light_t                lights,
  input  logic                  slots_valid,
  input  logic                  slots_ready,
  input  slot_t                 slots,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  output int                    fails,
  output int                    pending
);

  localparam int COUNT_CEIL = 511;

  logic signed [COORD_W-1:0] cam [AXES];
  logic [DIST_W-1:0]         near_dist [SLOT_COUNT];
  logic [IDX_W-1:0]          near_idx [SLOT_COUNT];
  int                        caster_total;
  logic [IDX_W-1:0]          arrival_idx;
  slot_t                     slots_due [$];
  int                        err_count = 0;

  function automatic logic [DIST_W-1:0] axis_sq(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    return DIST_W'(diff * diff);
  endfunction

  task automatic clear_frame();
    for (int k = 0; k < SLOT_COUNT; k++) begin
      near_dist[k] = '0;
      near_idx[k] = '0;
    end
    caster_total = 0;
    arrival_idx = '0;
  endtask

  task automatic rank_light(input light_t lt);
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] light_dist;
    int                filled;
    int                pos;
    slot_t             res;
    idx = arrival_idx;
    arrival_idx = arrival_idx + 1'b1;
    if (lt.casts_shadow) begin
      light_dist = axis_sq(lt.light_x, cam[CFG_CAMERA_X])
                 + axis_sq(lt.light_y, cam[CFG_CAMERA_Y])
                 + axis_sq(lt.light_z, cam[CFG_CAMERA_Z]);
      filled = (caster_total < SLOT_COUNT) ? caster_total : SLOT_COUNT;
      pos = 0;
      while (pos < filled && near_dist[pos] <= light_dist) pos++;
      if (pos < SLOT_COUNT) begin
        for (int k = SLOT_COUNT - 1; k > pos; k--) begin
          near_dist[k] = near_dist[k-1];
          near_idx[k] = near_idx[k-1];
        end
        near_dist[pos] = light_dist;
        near_idx[pos] = idx;
      end
      if (caster_total < COUNT_CEIL) caster_total++;
    end
    if (lt.last_light) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        res.slot_number = SLOT_W'(k);
        res.slot_valid = (k < caster_total);
        res.chosen_light = res.slot_valid ? near_idx[k] : '0;
        res.distance_squared = res.slot_valid ? near_dist[k] : '0;
        res.casters_dropped = (caster_total > SLOT_COUNT);
        res.last_slot = (k == SLOT_COUNT - 1);
        slots_due.push_back(res);
      end
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    slot_t want;
    if (rst) begin
      clear_frame();
      for (int a = 0; a < AXES; a++) cam[a] = '0;
      slots_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAMERA_X: cam[CFG_CAMERA_X] = cfg_data;
          CFG_CAMERA_Y: cam[CFG_CAMERA_Y] = cfg_data;
          CFG_CAMERA_Z: cam[CFG_CAMERA_Z] = cfg_data;
          default: ;
        endcase
      end
      if (lights_valid && lights_ready) rank_light(lights);
      if (slots_valid && slots_ready) begin
        if (slots_due.size() == 0) begin
          $error("slot item with nothing expected: slot_number %0d", slots.slot_number);
          err_count++;
        end else begin
          want = slots_due.pop_front();
          check_field("slot_number", want.slot_number, slots.slot_number);
          check_field("slot_valid", want.slot_valid, slots.slot_valid);
          check_field("chosen_light", want.chosen_light, slots.chosen_light);
          check_field("distance_squared", want.distance_squared, slots.distance_squared);
          check_field("casters_dropped", want.casters_dropped, slots.casters_dropped);
          check_field("last_slot", want.last_slot, slots.last_slot);
        end
      end
    end
    fails <= err_count;
    pending <= slots_due.size();
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import nscs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int COORD_MAX = 524287;
  localparam int COORD_MIN = -524288;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 lights_valid = 1'b0;
  logic                 lights_ready;
  light_t               lights = '0;
  logic                 slots_valid;
  logic                 slots_ready = 1'b0;
  slot_t                slots;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;
  int                   fails;
  int                   pending;
  int                   send_gap_pct = 0;
  int                   recv_gap_pct = 0;

  always #5 clk = ~clk;

  nearest_shadow_caster_select uut (.*);

  shadow_slot_checker slot_check (.*);

  always @(posedge clk) slots_ready <= ($urandom_range(99) >= recv_gap_pct);

  function automatic logic signed [COORD_W-1:0] pick_coord();
    int offset;
    offset = $urandom_range(32);
    case ($urandom_range(9))
      0: return COORD_W'(COORD_MAX);
      1: return COORD_W'(COORD_MIN);
      2, 3, 4: return COORD_W'(offset - 16);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic light_t make_light(bit casts, bit closes);
    light_t lt;
    lt.light_x = pick_coord();
    lt.light_y = pick_coord();
    lt.light_z = pick_coord();
    lt.casts_shadow = casts;
    lt.last_light = closes;
    return lt;
  endfunction

  function automatic light_t corner(int c, bit casts, bit closes);
    light_t lt;
    lt.light_x = COORD_W'(c);
    lt.light_y = COORD_W'(c);
    lt.light_z = COORD_W'(c);
    lt.casts_shadow = casts;
    lt.last_light = closes;
    return lt;
  endfunction

  task automatic send_light(input light_t lt);
    while ($urandom_range(99) < send_gap_pct) begin
      lights_valid <= 1'b0;
      @(posedge clk);
    end
    lights <= lt;
    lights_valid <= 1'b1;
    @(posedge clk);
    while (!lights_ready) @(posedge clk);
  endtask

  task automatic drain();
    lights_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_camera(input int x, input int y, input int z);
    put_reg(CFG_SPARE, COORD_W'($urandom));
    put_reg(CFG_CAMERA_X, COORD_W'(x));
    put_reg(CFG_CAMERA_Y, COORD_W'(y));
    put_reg(CFG_CAMERA_Z, COORD_W'(z));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int n, input int cast_pct);
    for (int i = 0; i < n; i++) send_light(make_light($urandom_range(99) < cast_pct, i == n - 1));
  endtask

  task automatic run_phase(input int quota);
    int sent;
    int n;
    sent = 0;
    while (sent < quota) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      send_frame(n, $urandom_range(20, 100));
      sent += n;
      if ($urandom_range(9) == 0) drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct = 31;
    recv_gap_pct = 74;
    set_camera(COORD_MIN, COORD_MIN, COORD_MIN);

    send_light(corner(COORD_MIN, 1'b0, 1'b1));
    send_light(corner(COORD_MAX, 1'b1, 1'b1));
    send_light(corner(COORD_MIN, 1'b1, 1'b0));
    send_light(corner(COORD_MAX, 1'b1, 1'b0));
    send_light(corner(COORD_MAX, 1'b0, 1'b1));
    drain();
    for (int i = 0; i < 6; i++) send_light(corner(COORD_MIN + 1, 1'b1, 1'b0));
    send_light(corner(COORD_MIN, 1'b1, 1'b1));
    for (int i = 4; i >= 1; i--) send_light(corner(COORD_MIN + i, 1'b1, i == 1));
    for (int i = 0; i < 5; i++) send_light(corner(COORD_MIN + (i % 3), 1'b1, i == 4));
    drain();

    set_camera(int'(pick_coord()), int'(pick_coord()), int'(pick_coord()));
    run_phase(50);
    drain();

    send_gap_pct = 74;
    recv_gap_pct = 31;
    set_camera(COORD_MAX, COORD_MAX, COORD_MAX);
    run_phase(50);
    drain();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_camera(0, 0, 0);
    send_frame(262, 15);
    run_phase(50);
    drain();

    if (fails == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/nscs_pkg.sv
rtl/nscs_dist.sv
rtl/nscs_insert.sv
rtl/nearest_shadow_caster_select.sv
tb/sv/shadow_slot_checker.sv
tb/sv/tb_top.sv
